@@ sv/tmoa_pkg.sv @@
// Shared constants, register codes and divider interface types for the
// trimmed-mean offset averager. No dependencies.
package tmoa_pkg;

	localparam int NUM_CHANNELS_DFLT = 16;

	localparam int CHAN_W      = 4;
	localparam int SAMPLE_W    = 12;
	localparam int COUNT_W     = 7;
	localparam int BIAS_W      = 13;
	localparam int SUM_W       = 19;
	localparam int NUM_W       = 22;
	localparam int MAG_W       = 21;
	localparam int RESULT_W    = 14;
	localparam int DIV_STEP_W  = 5;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 12;
	localparam int IN_DATA_W   = 16;
	localparam int OUT_DATA_W  = 24;

	localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RST = 7'd10;
	localparam logic [COUNT_W-1:0] SAMPLE_COUNT_MIN = 7'd3;
	localparam logic [COUNT_W-1:0] TRIM_DROP        = 7'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_VALUE = 1'b1;

	localparam logic FUNC_CALIBRATE = 1'b0;
	localparam logic FUNC_SAMPLE    = 1'b1;

	typedef struct packed {
		logic               start;
		logic [MAG_W-1:0]   mag;
		logic [COUNT_W-1:0] divisor;
	} tmoa_div_req_t;

	typedef struct packed {
		logic             busy;
		logic [MAG_W-1:0] quo;
	} tmoa_div_sts_t;

endpackage

@@ sv/tmoa_divider.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on tmoa_pkg for widths and the request/status structs.
module tmoa_divider import tmoa_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  tmoa_div_req_t req,
	output tmoa_div_sts_t sts
);

	logic                  busy_q;
	logic [DIV_STEP_W-1:0] step_q;
	logic [COUNT_W-1:0]    rem_q;
	logic [MAG_W-1:0]      quo_q;
	logic [COUNT_W-1:0]    dvs_q;

	logic [COUNT_W:0]      rem_sh;
	logic                  ge;
	logic [COUNT_W:0]      rem_sub;

	assign rem_sh  = {rem_q, quo_q[MAG_W-1]};
	assign ge      = rem_sh >= {1'b0, dvs_q};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			if (step_q == DIV_STEP_W'(MAG_W - 1)) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.mag;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			// The remainder always stays below the divisor, so it fits in COUNT_W bits.
			rem_q <= ge ? rem_sub[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
			quo_q <= {quo_q[MAG_W-2:0], ge};
		end
	end

	assign sts.busy = busy_q;
	assign sts.quo  = quo_q;

endmodule

@@ sv/tmoa_bias_store.sv @@
// Per-channel bias memory with a registered read and reset-cleared valid bits,
// so unwritten entries read as zero. Depends on tmoa_pkg.
module tmoa_bias_store import tmoa_pkg::*; #(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DFLT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     we,
	input  logic [CHAN_W-1:0]        wr_chan,
	input  logic signed [BIAS_W-1:0] wr_data,
	input  logic                     rd_en,
	input  logic [CHAN_W-1:0]        rd_chan,
	output logic signed [BIAS_W-1:0] rd_data
);

	localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	logic signed [BIAS_W-1:0] mem [NUM_CHANNELS];
	logic signed [BIAS_W-1:0] mem_q;
	logic [NUM_CHANNELS-1:0]  valid_q;
	logic                     hit_q;

	logic          wr_ok;
	logic          rd_ok;
	logic [AW-1:0] wr_idx;
	logic [AW-1:0] rd_idx;

	// Channels past the end of the store are ignored on write and read as zero.
	assign wr_ok  = we && (int'(wr_chan) < NUM_CHANNELS);
	assign rd_ok  = int'(rd_chan) < NUM_CHANNELS;
	assign wr_idx = AW'(wr_chan);
	assign rd_idx = AW'(rd_chan);

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			mem_q <= mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_q   <= 1'b0;
		end else begin
			if (wr_ok) begin
				valid_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				hit_q <= rd_ok && valid_q[rd_idx];
			end
		end
	end

	assign rd_data = hit_q ? mem_q : '0;

endmodule

@@ sv/trimmed_mean_offset_averager.sv @@
// Top level of the trimmed-mean offset averager: run tracking, control,
// output register. Depends on tmoa_pkg, tmoa_bias_store and tmoa_divider.
//
//  channel | direction | tdata / data bits                       | tuser
//  --------+-----------+-----------------------------------------+-------------
//  s_*     | in        | [3:0] channel, [15:4] sample            | [0] func
//  m_*     | out       | [3:0] out_channel, [17:4] corrected_val | none
//  cfg_*   | in        | cfg_index 0 = sample_count, 1 = target  | none
//
// A calibrate word or a sample word that does not close a run is taken without
// holding the input. A sample word that closes a run holds the input until its
// result is loaded: the channel bias is read from the bias memory, the numerator
// is formed and the divider started, the bit-serial divider produces one quotient
// bit per cycle, and the output register is loaded. Reset clears the run state
// and sets the configuration to its defaults; the bias memory reads as zero
// until an entry is calibrated. A stalled output only holds the block when a
// new result is ready while the previous one still waits in the output register.
module trimmed_mean_offset_averager import tmoa_pkg::*; #(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DFLT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [3:0] channel, [15:4] sample
	input  logic [0:0]            s_tuser,   // [0] func
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [3:0] out_channel, [17:4] corrected_value
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_RDBIAS = 3'b010,
		ST_DIV    = 3'b100
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [COUNT_W-1:0]  sample_count_q;
	logic [SAMPLE_W-1:0] target_value_q;

	// Running statistics of the current run.
	logic [SUM_W-1:0]    run_sum_q;
	logic [SAMPLE_W-1:0] run_max_q;
	logic [SAMPLE_W-1:0] run_min_q;
	logic [COUNT_W-1:0]  run_count_q;
	logic [CHAN_W-1:0]   run_chan_q;

	logic neg_q;

	// Output register.
	logic                m_tvalid_q;
	logic [CHAN_W-1:0]   out_chan_q;
	logic [RESULT_W-1:0] out_value_q;

	// Input word fields.
	logic                in_func;
	logic [CHAN_W-1:0]   in_chan;
	logic [SAMPLE_W-1:0] in_sample;

	logic s_accept;
	logic cal_we;
	logic smp_acc;
	logic run_first;
	logic run_end;

	logic [CHAN_W-1:0]        run_chan_nx;
	logic [COUNT_W-1:0]       count_nx;
	logic [COUNT_W-1:0]       n_eff;
	logic signed [BIAS_W-1:0] cal_bias;
	logic signed [BIAS_W-1:0] bias_rd;

	// Numerator path, evaluated in the bias read cycle.
	logic [COUNT_W-1:0]              divisor;
	logic [SUM_W-1:0]                trimmed;
	logic signed [BIAS_W+COUNT_W:0]  prod;
	logic signed [NUM_W-1:0]         num;
	logic [MAG_W-1:0]                mag;

	logic [RESULT_W-1:0] quo_trunc;
	logic [RESULT_W-1:0] result;
	logic                out_load;

	tmoa_div_req_t div_req;
	tmoa_div_sts_t div_sts;

	assign in_func   = s_tuser[0];
	assign in_chan   = s_tdata[CHAN_W-1:0];
	assign in_sample = s_tdata[CHAN_W+SAMPLE_W-1:CHAN_W];

	// Words are taken only when no run end is being worked on.
	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign cal_we   = s_accept && (in_func == FUNC_CALIBRATE);
	assign smp_acc  = s_accept && (in_func == FUNC_SAMPLE);

	assign cal_bias = $signed({1'b0, target_value_q}) - $signed({1'b0, in_sample});

	// The first sample of a run fixes its channel. A run length below the
	// minimum is raised to it, so the divisor is never zero.
	assign run_first   = (run_count_q == '0);
	assign run_chan_nx = run_first ? in_chan : run_chan_q;
	assign count_nx    = run_count_q + 1'b1;
	assign n_eff       = (sample_count_q < SAMPLE_COUNT_MIN) ? SAMPLE_COUNT_MIN : sample_count_q;
	assign run_end     = smp_acc && (count_nx >= n_eff);

	tmoa_bias_store #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_bias_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (cal_we),
		.wr_chan (in_chan),
		.wr_data (cal_bias),
		.rd_en   (run_end),
		.rd_chan (run_chan_nx),
		.rd_data (bias_rd)
	);

	// The bias is added as bias*(n-2) before the division so that the
	// truncation toward zero covers the mean and the bias together.
	assign divisor = run_count_q - TRIM_DROP;
	assign trimmed = run_sum_q - SUM_W'(run_max_q) - SUM_W'(run_min_q);
	assign prod    = bias_rd * $signed({1'b0, divisor});
	assign num     = $signed({{(NUM_W-SUM_W){1'b0}}, trimmed}) + NUM_W'(prod);
	assign mag     = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);

	assign div_req.start   = (state_q == ST_RDBIAS);
	assign div_req.mag     = mag;
	assign div_req.divisor = divisor;

	tmoa_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.sts    (div_sts)
	);

	// Only the low result bits are kept, so the sign is applied after truncation.
	assign quo_trunc = div_sts.quo[RESULT_W-1:0];
	assign result    = neg_q ? (~quo_trunc + 1'b1) : quo_trunc;
	assign out_load  = (state_q == ST_DIV) && !div_sts.busy && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= SAMPLE_COUNT_RST;
			target_value_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SAMPLE_COUNT: sample_count_q <= cfg_data[COUNT_W-1:0];
				CFG_TARGET_VALUE: target_value_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			run_count_q <= '0;
			run_sum_q   <= '0;
			run_max_q   <= '0;
			run_min_q   <= '0;
			run_chan_q  <= '0;
			neg_q       <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (smp_acc) begin
						run_chan_q  <= run_chan_nx;
						run_count_q <= count_nx;
						if (run_first) begin
							run_sum_q <= SUM_W'(in_sample);
							run_max_q <= in_sample;
							run_min_q <= in_sample;
						end else begin
							run_sum_q <= run_sum_q + SUM_W'(in_sample);
							if (in_sample > run_max_q) begin
								run_max_q <= in_sample;
							end
							if (in_sample < run_min_q) begin
								run_min_q <= in_sample;
							end
						end
					end
					if (run_end) begin
						state_q <= ST_RDBIAS;
					end
				end
				ST_RDBIAS: begin
					neg_q       <= num[NUM_W-1];
					run_count_q <= '0;
					state_q     <= ST_DIV;
				end
				ST_DIV: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_chan_q  <= run_chan_q;
			out_value_q <= result;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_DATA_W-CHAN_W-RESULT_W){1'b0}}, out_value_q, out_chan_q};

	// A run end always moves on to the bias read.
	a_run_end_reads_bias: assert property (@(posedge clk) disable iff (!arst_n)
		run_end |=> state_q == ST_RDBIAS)
		else $error("run end did not start the bias read");

	// The divider is only started while idle.
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_sts.busy)
		else $error("divider started while busy");

	// A new result appears only as the divider finishes.
	a_result_from_div: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_DIV) && $past(!div_sts.busy))
		else $error("result word without a finished division");

	// The run count is cleared once its result is on the way.
	a_count_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> run_count_q == '0)
		else $error("run count not cleared during division");

endmodule

@@ tb/averager_checker.sv @@
// Watches the word, result and register ports of the trimmed-mean offset averager,
// predicts every run average and compares it with what the block delivers.
// Depends on tmoa_pkg.
module averager_checker import tmoa_pkg::*; #(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DFLT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [3:0] channel, [15:4] sample
	input  logic [0:0]            s_tuser,   // [0] func
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,   // [3:0] out_channel, [17:4] corrected_value
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    errors,
	output int                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [CHAN_W-1:0]   chan;
		logic [RESULT_W-1:0] value;
	} run_average_t;

	run_average_t averages_due[$];

	logic signed [BIAS_W-1:0] chan_bias [NUM_CHANNELS];
	logic [SUM_W-1:0]         acc_sum;
	logic [SAMPLE_W-1:0]      acc_max;
	logic [SAMPLE_W-1:0]      acc_min;
	logic [COUNT_W-1:0]       acc_count;
	logic [CHAN_W-1:0]        acc_chan;
	logic [COUNT_W-1:0]       run_len;
	logic [SAMPLE_W-1:0]      target;

	// Applies one accepted word to the model and queues the average of a run it closes.
	task automatic take_word(input logic func, input logic [CHAN_W-1:0] ch,
			input logic [SAMPLE_W-1:0] smp);
		logic [COUNT_W-1:0] len;
		int                 bias;
		int                 divisor;
		int                 numer;
		run_average_t       avg;
		if (func == FUNC_CALIBRATE) begin
			if (ch < NUM_CHANNELS)
				chan_bias[ch] = BIAS_W'(int'(target) - int'(smp));
			return;
		end
		if (acc_count == '0) begin
			acc_chan = ch;
			acc_sum  = SUM_W'(smp);
			acc_max  = smp;
			acc_min  = smp;
		end else begin
			acc_sum = acc_sum + SUM_W'(smp);
			if (smp > acc_max)
				acc_max = smp;
			if (smp < acc_min)
				acc_min = smp;
		end
		acc_count = acc_count + 1'b1;
		len = (run_len < SAMPLE_COUNT_MIN) ? SAMPLE_COUNT_MIN : run_len;
		if (acc_count < len)
			return;
		// The bias is read as it stands when the run closes.
		bias    = (acc_chan < NUM_CHANNELS) ? int'(chan_bias[acc_chan]) : 0;
		divisor = int'(acc_count) - int'(TRIM_DROP);
		numer   = int'(acc_sum) - int'(acc_max) - int'(acc_min) + bias * divisor;
		avg.chan  = acc_chan;
		avg.value = RESULT_W'(numer / divisor);
		averages_due.push_back(avg);
		acc_count = '0;
		acc_sum   = '0;
		acc_max   = '0;
		acc_min   = '0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (chan_bias[k])
				chan_bias[k] = '0;
			acc_sum   = '0;
			acc_max   = '0;
			acc_min   = '0;
			acc_count = '0;
			acc_chan  = '0;
			run_len   = SAMPLE_COUNT_RST;
			target    = '0;
			averages_due.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (averages_due.size() == 0) begin
					$display("%0t: unexpected result channel %0d value %0d", $time,
						m_tdata[CHAN_W-1:0], $signed(m_tdata[CHAN_W+RESULT_W-1:CHAN_W]));
					errors++;
				end else begin
					run_average_t want;
					want = averages_due.pop_front();
					if (m_tdata[CHAN_W-1:0] !== want.chan) begin
						$display("%0t: out_channel expected %0d actual %0d", $time,
							want.chan, m_tdata[CHAN_W-1:0]);
						errors++;
					end
					if (m_tdata[CHAN_W+RESULT_W-1:CHAN_W] !== want.value) begin
						$display("%0t: corrected_value expected %0d actual %0d", $time,
							$signed(want.value),
							$signed(m_tdata[CHAN_W+RESULT_W-1:CHAN_W]));
						errors++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_SAMPLE_COUNT: run_len = cfg_data[COUNT_W-1:0];
					CFG_TARGET_VALUE: target  = cfg_data[SAMPLE_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				take_word(s_tuser[0], s_tdata[CHAN_W-1:0],
					s_tdata[CHAN_W+SAMPLE_W-1:CHAN_W]);
		end
		pending <= averages_due.size();
	end

endmodule

@@ tb/testbench.sv @@
// Top of the averager testbench: clock, reset, word and register stimulus, output
// back-pressure and the verdict. Depends on tmoa_pkg, averager_checker and the RTL.
module testbench import tmoa_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	// Long enough for a run-closing word, which holds the input until its result is
	// loaded, and for the output register, before a register write or the final verdict.
	localparam int SETTLE_CYCLES = 32;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int NUM_PHASES = 14;
	localparam int PHASE_WORDS = 100;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [0:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int          errors;
	int          pending;
	int          idle_pct = 0;
	int          stall_pct = 0;
	int unsigned cycle_count = 0;

	trimmed_mean_offset_averager i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	averager_checker i_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The receiver drops tready at random; the rate follows the current phase.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Offers one word, after a random number of idle cycles, and returns once it
	// has been taken. Valid stays high into the next word when no gap is drawn.
	task automatic send_word(input logic func, input logic [CHAN_W-1:0] ch,
			input logic [SAMPLE_W-1:0] smp);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= {smp, ch};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// Stops sending and waits until every queued average has come out and the
	// block has had time to finish any work still inside it.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes both registers on back-to-back edges; only called while settled.
	task automatic program_regs(input logic [COUNT_W-1:0] len,
			input logic [SAMPLE_W-1:0] tgt);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_SAMPLE_COUNT;
		cfg_data  <= CFG_DATA_W'(len);
		@(posedge clk);
		cfg_index <= CFG_TARGET_VALUE;
		cfg_data  <= tgt;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Readings lean toward the rails so that extremes and sums near the top show up.
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return SAMPLE_W'($urandom_range(4095));
		endcase
	endfunction

	// Mostly short runs; now and then a length below the minimum or a very long one.
	function automatic logic [COUNT_W-1:0] pick_len();
		case ($urandom_range(9))
			0: return COUNT_W'($urandom_range(2));
			1: return COUNT_W'($urandom_range(127, 90));
			default: return COUNT_W'($urandom_range(12, 3));
		endcase
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_target();
		case ($urandom_range(3))
			0: return '0;
			1: return '1;
			default: return SAMPLE_W'($urandom_range(4095));
		endcase
	endfunction

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Largest result: bias +4095 on a run of full-scale readings.
		program_regs(7'd3, 12'd4095);
		send_word(FUNC_CALIBRATE, 4'd15, 12'd0);
		send_word(FUNC_SAMPLE, 4'd15, 12'd4095);
		send_word(FUNC_SAMPLE, 4'd15, 12'd4095);
		send_word(FUNC_SAMPLE, 4'd15, 12'd4095);
		// Zero bias; the middle reading survives the trim.
		send_word(FUNC_CALIBRATE, 4'd0, 12'd4095);
		send_word(FUNC_SAMPLE, 4'd0, 12'd0);
		send_word(FUNC_SAMPLE, 4'd0, 12'd4095);
		send_word(FUNC_SAMPLE, 4'd0, 12'd2048);
		settle();

		// Bias -4095 and a fractional mean that must truncate toward zero.
		program_regs(7'd4, 12'd0);
		send_word(FUNC_CALIBRATE, 4'd1, 12'd4095);
		send_word(FUNC_SAMPLE, 4'd1, 12'd0);
		send_word(FUNC_SAMPLE, 4'd1, 12'd1);
		send_word(FUNC_SAMPLE, 4'd1, 12'd2);
		send_word(FUNC_SAMPLE, 4'd1, 12'd4095);
		// Calibration in the middle of a run; later words carry another channel,
		// but the run stays on the channel of its first sample.
		send_word(FUNC_SAMPLE, 4'd2, 12'd100);
		send_word(FUNC_SAMPLE, 4'd2, 12'd200);
		send_word(FUNC_CALIBRATE, 4'd2, 12'd10);
		send_word(FUNC_SAMPLE, 4'd7, 12'd300);
		send_word(FUNC_SAMPLE, 4'd7, 12'd400);
		settle();

		// A run length of zero behaves as the minimum of three: the smallest result.
		program_regs(7'd0, 12'd4095);
		send_word(FUNC_SAMPLE, 4'd1, 12'd0);
		send_word(FUNC_SAMPLE, 4'd1, 12'd0);
		send_word(FUNC_SAMPLE, 4'd1, 12'd0);
		settle();
		program_regs(7'd2, 12'd4095);
		send_word(FUNC_SAMPLE, 4'd3, 12'd5);
		send_word(FUNC_SAMPLE, 4'd3, 12'd9);
		send_word(FUNC_SAMPLE, 4'd3, 12'd7);
		settle();

		// Shortening the run length mid-run closes the run at the next sample,
		// with the divisor taken from the actual count.
		program_regs(7'd127, 12'd4095);
		send_word(FUNC_SAMPLE, 4'd4, 12'd10);
		send_word(FUNC_SAMPLE, 4'd4, 12'd20);
		send_word(FUNC_SAMPLE, 4'd4, 12'd30);
		send_word(FUNC_SAMPLE, 4'd4, 12'd40);
		send_word(FUNC_SAMPLE, 4'd4, 12'd50);
		settle();
		program_regs(7'd3, 12'd4095);
		send_word(FUNC_SAMPLE, 4'd4, 12'd60);
		settle();

		// The longest run, mostly full scale, drives the sum near its top.
		program_regs(7'd127, pick_target());
		send_word(FUNC_CALIBRATE, 4'd9, pick_sample());
		repeat (127)
			send_word(FUNC_SAMPLE, 4'd9,
				($urandom_range(3) == 0) ? SAMPLE_W'($urandom_range(4095)) : 12'hFFF);
		settle();

		// Random phases cycle through the idling mixes; runs left open at a phase
		// boundary carry on under the new run length.
		for (int p = 0; p < NUM_PHASES; p++) begin
			settle();
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 53; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 53; end
				default: begin idle_pct = 16; stall_pct = 16; end
			endcase
			program_regs(pick_len(), pick_target());
			repeat (PHASE_WORDS) begin
				if ($urandom_range(6) == 0)
					send_word(FUNC_CALIBRATE, CHAN_W'($urandom_range(15)), pick_sample());
				else
					send_word(FUNC_SAMPLE, CHAN_W'($urandom_range(15)), pick_sample());
			end
		end

		settle();
		if (errors == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

@@ sim.f @@
sv/tmoa_pkg.sv
sv/tmoa_divider.sv
sv/tmoa_bias_store.sv
sv/trimmed_mean_offset_averager.sv
tb/averager_checker.sv
tb/testbench.sv
